### rtl/glob_pkg.sv
// ----------------------------------------------------------------------------
// glob_pkg
// Shared types and constants for the wildcard glob matcher: store depths,
// derived widths, wildcard symbols, beat payloads and control/status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package glob_pkg;

    // Store depths
    localparam int MAX_PATTERN = 64;
    localparam int MAX_TEXT    = 256;

    // Address widths (entries) and length widths (0 .. depth)
    localparam int PAT_AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int PAT_LW = $clog2(MAX_PATTERN + 1);
    localparam int TXT_AW = (MAX_TEXT > 1) ? $clog2(MAX_TEXT) : 1;
    localparam int TXT_LW = $clog2(MAX_TEXT + 1);

    localparam logic [PAT_LW-1:0] PAT_DEPTH = PAT_LW'(MAX_PATTERN);
    localparam logic [TXT_LW-1:0] TXT_DEPTH = TXT_LW'(MAX_TEXT);

    // Wildcard symbols
    localparam logic [7:0] SYM_ANY_ONE = 8'h3F;  // question mark
    localparam logic [7:0] SYM_ANY_RUN = 8'h2A;  // star

    // Input beat
    typedef struct packed {
        logic [7:0] char_byte;
        logic       is_pattern;
        logic       last;
    } glob_in_t;

    // Result beat
    typedef struct packed {
        logic matched;
        logic overflow;
    } glob_out_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic accept;     // input beat taken: store the byte
        logic walk_init;  // clear walk indices
        logic step;       // apply one greedy/backtrack step
        logic tail_step;  // skip one trailing star
        logic emit;       // load result and clear the text store
        logic hit;        // match verdict carried with emit
    } glob_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic ovf;        // pattern or text overflow
        logic text_done;  // text index has reached text length
        logic pat_end;    // pattern index equals pattern length
        logic step_fail;  // no rule applies: mismatch without a star
        logic pat_star;   // pattern byte at index is a star
    } glob_sts_t;

endpackage

`default_nettype wire

### rtl/glob_dpath.sv
// ----------------------------------------------------------------------------
// glob_dpath
// Datapath: pattern and text stores with registered reads, length and
// overflow tracking, walk indices with star backtracking, and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module glob_dpath (
    input  wire                  clk,
    input  wire                  rst_n,
    input  glob_pkg::glob_in_t   in_data,
    input  glob_pkg::glob_cmd_t  cmd,
    output glob_pkg::glob_sts_t  sts,
    output glob_pkg::glob_out_t  out_data
);
    import glob_pkg::*;

    logic [7:0]        pat_mem [MAX_PATTERN];
    logic [7:0]        txt_mem [MAX_TEXT];
    logic [7:0]        pat_rd_reg;
    logic [7:0]        txt_rd_reg;

    logic [PAT_LW-1:0] pat_len_reg,  pat_len_next;
    logic              pat_closed_reg, pat_closed_next;
    logic              pat_ovf_reg,  pat_ovf_next;
    logic [TXT_LW-1:0] txt_len_reg,  txt_len_next;
    logic              txt_ovf_reg,  txt_ovf_next;

    logic [PAT_LW-1:0] pi_reg,   pi_next;
    logic [PAT_LW-1:0] star_reg, star_next;
    logic [TXT_LW-1:0] ti_reg,   ti_next;
    logic [TXT_LW-1:0] resume_reg, resume_next;
    logic              have_star_reg, have_star_next;

    glob_out_t         result_reg;

    logic [PAT_LW-1:0] pat_wr_pos;
    logic              pat_wr_en;
    logic              txt_wr_en;
    logic              pi_valid;
    logic              match_one;
    logic              match_star;

    // Write position: a closed pattern restarts from zero
    always_comb
    begin
        pat_wr_pos = pat_closed_reg ? '0 : pat_len_reg;
        pat_wr_en  = cmd.accept && in_data.is_pattern && (pat_wr_pos < PAT_DEPTH);
        txt_wr_en  = cmd.accept && !in_data.is_pattern && (txt_len_reg < TXT_DEPTH);
    end

    // Store writes and registered reads at the walk indices
    always_ff @(posedge clk)
    begin
        if (pat_wr_en)
        begin
            pat_mem[pat_wr_pos[PAT_AW-1:0]] <= in_data.char_byte;
        end
        if (txt_wr_en)
        begin
            txt_mem[txt_len_reg[TXT_AW-1:0]] <= in_data.char_byte;
        end
        pat_rd_reg <= pat_mem[pi_reg[PAT_AW-1:0]];
        txt_rd_reg <= txt_mem[ti_reg[TXT_AW-1:0]];
    end

    // Step classification on the read data
    always_comb
    begin
        pi_valid   = (pi_reg < pat_len_reg);
        match_one  = pi_valid && ((pat_rd_reg == SYM_ANY_ONE) || (pat_rd_reg == txt_rd_reg));
        match_star = pi_valid && (pat_rd_reg == SYM_ANY_RUN);

        sts.ovf       = pat_ovf_reg || txt_ovf_reg;
        sts.text_done = (ti_reg >= txt_len_reg);
        sts.pat_end   = (pi_reg == pat_len_reg);
        sts.step_fail = !match_one && !match_star && !have_star_reg;
        sts.pat_star  = (pat_rd_reg == SYM_ANY_RUN);
    end

    // Length and overflow bookkeeping
    always_comb
    begin
        pat_len_next    = pat_len_reg;
        pat_closed_next = pat_closed_reg;
        pat_ovf_next    = pat_ovf_reg;
        txt_len_next    = txt_len_reg;
        txt_ovf_next    = txt_ovf_reg;

        if (cmd.accept && in_data.is_pattern)
        begin
            pat_closed_next = in_data.last;
            if (pat_wr_en)
            begin
                pat_len_next = pat_wr_pos + PAT_LW'(1);
                pat_ovf_next = pat_closed_reg ? 1'b0 : pat_ovf_reg;
            end
            else
            begin
                pat_len_next = pat_wr_pos;
                pat_ovf_next = 1'b1;
            end
        end
        else if (cmd.accept)
        begin
            if (txt_wr_en)
            begin
                txt_len_next = txt_len_reg + TXT_LW'(1);
            end
            else
            begin
                txt_ovf_next = 1'b1;
            end
        end

        if (cmd.emit)
        begin
            txt_len_next = '0;
            txt_ovf_next = 1'b0;
        end
    end

    // Walk index update: advance, note a star, or backtrack to it
    always_comb
    begin
        pi_next        = pi_reg;
        ti_next        = ti_reg;
        star_next      = star_reg;
        resume_next    = resume_reg;
        have_star_next = have_star_reg;

        if (cmd.walk_init)
        begin
            pi_next        = '0;
            ti_next        = '0;
            star_next      = '0;
            resume_next    = '0;
            have_star_next = 1'b0;
        end
        else if (cmd.step)
        begin
            if (match_one)
            begin
                pi_next = pi_reg + PAT_LW'(1);
                ti_next = ti_reg + TXT_LW'(1);
            end
            else if (match_star)
            begin
                have_star_next = 1'b1;
                star_next      = pi_reg;
                pi_next        = pi_reg + PAT_LW'(1);
                resume_next    = ti_reg;
            end
            else
            begin
                pi_next     = star_reg + PAT_LW'(1);
                resume_next = resume_reg + TXT_LW'(1);
                ti_next     = resume_reg + TXT_LW'(1);
            end
        end
        else if (cmd.tail_step)
        begin
            pi_next = pi_reg + PAT_LW'(1);
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_len_reg    <= '0;
            pat_closed_reg <= 1'b1;
            pat_ovf_reg    <= 1'b0;
            txt_len_reg    <= '0;
            txt_ovf_reg    <= 1'b0;
        end
        else
        begin
            pat_len_reg    <= pat_len_next;
            pat_closed_reg <= pat_closed_next;
            pat_ovf_reg    <= pat_ovf_next;
            txt_len_reg    <= txt_len_next;
            txt_ovf_reg    <= txt_ovf_next;
        end
    end

    // Walk registers and result payload
    always_ff @(posedge clk)
    begin
        pi_reg        <= pi_next;
        ti_reg        <= ti_next;
        star_reg      <= star_next;
        resume_reg    <= resume_next;
        have_star_reg <= have_star_next;
        if (cmd.emit)
        begin
            result_reg.matched  <= cmd.hit && !(pat_ovf_reg || txt_ovf_reg);
            result_reg.overflow <= pat_ovf_reg || txt_ovf_reg;
        end
    end

    assign out_data = result_reg;

`ifndef NO_ASSERTIONS
    // A walk step is only taken while text remains
    a_step_in_text: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> (ti_reg < txt_len_reg))
        else $error("walk step beyond text end");

    // Trailing star skip never runs past the pattern end
    a_tail_in_pat: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.tail_step |-> (pi_reg < pat_len_reg))
        else $error("tail skip beyond pattern end");

    // Stored lengths never pass the store depths
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (pat_len_reg <= PAT_DEPTH) && (txt_len_reg <= TXT_DEPTH))
        else $error("store length beyond depth");
`endif

endmodule

`default_nettype wire

### rtl/glob_ctrl.sv
// ----------------------------------------------------------------------------
// glob_ctrl
// Controller: takes input beats, sequences the match walk over the stores
// (read then evaluate), and hands the verdict to the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module glob_ctrl (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  in_valid,
    input  glob_pkg::glob_in_t   in_data,
    output logic                 in_stall,
    output logic                 out_valid,
    input  wire                  out_stall,
    input  glob_pkg::glob_sts_t  sts,
    output glob_pkg::glob_cmd_t  cmd
);
    import glob_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_LOOP,
        ST_EVAL,
        ST_TAIL,
        ST_TAIL_EVAL,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   hit_reg, hit_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;
    logic   in_take;

    assign slot_free = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_take   = in_valid && (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        hit_next       = hit_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        cmd.hit        = hit_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    cmd.accept = 1'b1;
                    if (!in_data.is_pattern && in_data.last)
                    begin
                        state_next = ST_START;
                    end
                end
            end
            ST_START:
            begin
                cmd.walk_init = 1'b1;
                if (sts.ovf)
                begin
                    hit_next   = 1'b0;
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_LOOP;
                end
            end
            ST_LOOP:
            begin
                state_next = sts.text_done ? ST_TAIL : ST_EVAL;
            end
            ST_EVAL:
            begin
                if (sts.step_fail)
                begin
                    hit_next   = 1'b0;
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.step   = 1'b1;
                    state_next = ST_LOOP;
                end
            end
            ST_TAIL:
            begin
                if (sts.pat_end)
                begin
                    hit_next   = 1'b1;
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_TAIL_EVAL;
                end
            end
            ST_TAIL_EVAL:
            begin
                if (sts.pat_star)
                begin
                    cmd.tail_step = 1'b1;
                    state_next    = ST_TAIL;
                end
                else
                begin
                    hit_next   = 1'b0;
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (slot_free)
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef NO_ASSERTIONS
    // A result beat only appears straight after the finish state
    a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result raised outside finish");

    // Never overwrite a result still waiting downstream
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> slot_free)
        else $error("result overwritten while stalled");

    // Last text beat always starts a walk on the next cycle
    a_walk_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept && !in_data.is_pattern && in_data.last) |=> (state_reg == ST_START))
        else $error("walk did not start after last text beat");
`endif

endmodule

`default_nettype wire

### rtl/wildcard_glob_matcher_unit.sv
// A pattern or text beat is stored when taken. The last text beat starts a walk of S
// steps (store read, then compare), then skips trailing stars, a non-star ending it
// with no match; an overflow skips the walk. The result leaves the finish state once
// the result register is free. S stays below about pattern length times text length,
// some 16k. Input is taken 1 beat per cycle between texts; the result register lets
// the next pattern or text load while a result waits. Reset: empty closed pattern.
// ----------------------------------------------------------------------------
// wildcard_glob_matcher_unit
// Glob matcher with star and question mark: stores a pattern, buffers text,
// then walks both greedily with backtracking and emits match or no match.
// ----------------------------------------------------------------------------
`default_nettype none

module wildcard_glob_matcher_unit (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  in_valid,
    output logic                 in_stall,
    input  glob_pkg::glob_in_t   in_data,
    output logic                 out_valid,
    input  wire                  out_stall,
    output glob_pkg::glob_out_t  out_data
);
    import glob_pkg::*;

    glob_cmd_t cmd;
    glob_sts_t sts;

    // Sequence the walk
    glob_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_data   (in_data),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Stores, indices and result
    glob_dpath u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .cmd      (cmd),
        .sts      (sts),
        .out_data (out_data)
    );

endmodule

`default_nettype wire

### tb/sv/wildcard_glob_matcher_unit_test.sv
// ----------------------------------------------------------------------------
// wildcard_glob_matcher_unit_test
// Streams patterns and texts into the glob matcher under random valid/stall
// gaps. Every accepted beat also goes to a scoreboard that keeps its own copy
// of the pattern and text stores and runs the star/question-mark walk, so each
// match/no-match beat is checked against a verdict worked out here.
// ----------------------------------------------------------------------------
module wildcard_glob_matcher_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import glob_pkg::*;

    typedef logic [7:0] byte_q_t[$];

    // Scoreboard: mirrors the stores and predicts one verdict per text
    class glob_verdict_board;
        logic [7:0]  pat_bytes [MAX_PATTERN];
        int unsigned pat_len;
        bit          pat_closed;
        bit          pat_ovf;
        logic [7:0]  txt_bytes [MAX_TEXT];
        int unsigned txt_len;
        bit          txt_ovf;
        glob_out_t   pending_verdicts[$];
        int unsigned mismatches;

        function new();
            pat_len    = 0;
            pat_closed = 1'b1;
            pat_ovf    = 1'b0;
            txt_len    = 0;
            txt_ovf    = 1'b0;
            mismatches = 0;
        endfunction

        // Greedy walk, falling back to the most recent star on a mismatch
        function bit walk_matches();
            int unsigned pat_idx;
            int unsigned txt_idx;
            int unsigned star_idx;
            int unsigned resume_idx;
            bit          seen_star;
            pat_idx    = 0;
            txt_idx    = 0;
            star_idx   = 0;
            resume_idx = 0;
            seen_star  = 1'b0;
            while (txt_idx < txt_len)
            begin
                if (pat_idx < pat_len && (pat_bytes[pat_idx] == SYM_ANY_ONE ||
                                          pat_bytes[pat_idx] == txt_bytes[txt_idx]))
                begin
                    pat_idx++;
                    txt_idx++;
                end
                else if (pat_idx < pat_len && pat_bytes[pat_idx] == SYM_ANY_RUN)
                begin
                    seen_star  = 1'b1;
                    star_idx   = pat_idx;
                    pat_idx++;
                    resume_idx = txt_idx;
                end
                else if (seen_star)
                begin
                    pat_idx = star_idx + 1;
                    resume_idx++;
                    txt_idx = resume_idx;
                end
                else
                begin
                    return 1'b0;
                end
            end
            // skip stars left at the end of the pattern
            while (pat_idx < pat_len && pat_bytes[pat_idx] == SYM_ANY_RUN)
                pat_idx++;
            return pat_idx == pat_len;
        endfunction

        // Note one accepted input beat
        function void take_byte(glob_in_t beat);
            glob_out_t verdict;
            if (beat.is_pattern)
            begin
                // a pattern beat after a closed pattern starts afresh
                if (pat_closed)
                begin
                    pat_len    = 0;
                    pat_ovf    = 1'b0;
                    pat_closed = 1'b0;
                end
                if (pat_len < MAX_PATTERN)
                begin
                    pat_bytes[pat_len] = beat.char_byte;
                    pat_len++;
                end
                else
                begin
                    pat_ovf = 1'b1;
                end
                if (beat.last)
                    pat_closed = 1'b1;
            end
            else
            begin
                if (txt_len < MAX_TEXT)
                begin
                    txt_bytes[txt_len] = beat.char_byte;
                    txt_len++;
                end
                else
                begin
                    txt_ovf = 1'b1;
                end
                if (beat.last)
                begin
                    verdict.overflow = pat_ovf || txt_ovf;
                    verdict.matched  = !verdict.overflow && walk_matches();
                    pending_verdicts = {pending_verdicts, verdict};
                    txt_len = 0;
                    txt_ovf = 1'b0;
                end
            end
        endfunction

        // Compare one accepted result beat with the oldest verdict
        function void check_verdict(glob_out_t got);
            glob_out_t want;
            if (pending_verdicts.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result beat matched=%0b overflow=%0b",
                             $time, got.matched, got.overflow);
                return;
            end
            want = pending_verdicts.pop_front();
            if (got.matched !== want.matched || got.overflow !== want.overflow)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: verdict wrong: expected matched=%0b overflow=%0b, got %0b %0b",
                             $time, want.matched, want.overflow, got.matched, got.overflow);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    glob_in_t    in_data;
    logic        out_valid;
    logic        out_stall;
    glob_out_t   out_data;

    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned beats_sent;
    byte_q_t     cur_pattern;
    bit          pat_open;

    glob_verdict_board board = new();

    wildcard_glob_matcher_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Bound the run
    initial
    begin
        #30_000_000;
        $display("[wildcard_glob_matcher_unit] ERROR");
        $finish;
    end

    // Receiver: stall at random on the falling edge
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            out_stall <= (recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
        end
    end

    // Check every result beat taken at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_verdict(out_data);
    end

    function automatic logic [7:0] pick_letter();
        if ($urandom_range(9) == 0)
            return 8'($urandom_range(255));
        return 8'h61 + 8'($urandom_range(2));
    endfunction

    function automatic logic [7:0] pick_pattern_byte();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 20)
            return SYM_ANY_RUN;
        if (roll < 35)
            return SYM_ANY_ONE;
        return pick_letter();
    endfunction

    // Build a text that mostly fits the pattern, sometimes with one byte spoilt
    function automatic byte_q_t text_like(byte_q_t pat);
        byte_q_t txt;
        foreach (pat[i])
        begin
            if (pat[i] == SYM_ANY_RUN)
                repeat ($urandom_range(3)) txt = {txt, pick_letter()};
            else if (pat[i] == SYM_ANY_ONE)
                txt = {txt, pick_letter()};
            else
                txt = {txt, pat[i]};
        end
        if (txt.size() != 0 && $urandom_range(3) == 0)
            txt[$urandom_range(txt.size() - 1)] = pick_letter();
        if (txt.size() == 0)
            txt = {txt, pick_letter()};
        return txt;
    endfunction

    // Present one beat, with random idle cycles ahead of it; hold until taken
    task automatic send_beat(logic [7:0] value, bit is_pat, bit is_last_beat);
        glob_in_t beat;
        beat.char_byte  = value;
        beat.is_pattern = is_pat;
        beat.last       = is_last_beat;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.take_byte(beat);
        beats_sent++;
        @(negedge clk);
    endtask

    task automatic send_run(byte_q_t run, bit is_pat, bit close_run);
        foreach (run[i])
            send_beat(run[i], is_pat, close_run && i == run.size() - 1);
    endtask

    task automatic send_str(string s, bit is_pat, bit close_run);
        for (int i = 0; i < s.len(); i++)
            send_beat(s[i], is_pat, close_run && i == s.len() - 1);
    endtask

    // Hold off the sender until every pending verdict has come back
    task automatic wait_for_verdicts();
        in_valid <= 1'b0;
        while (board.pending_verdicts.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Random sequences of patterns and texts until the beat count is reached
    task automatic run_phase(int unsigned send_pct, int unsigned recv_pct,
                             int unsigned beat_goal);
        byte_q_t     run;
        int unsigned choice;
        int unsigned len;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        while (beats_sent < beat_goal)
        begin
            run.delete();
            choice = $urandom_range(99);
            if (choice < 30)
            begin
                // pattern: closed in full, or an open fragment that later beats extend
                if (choice < 22)
                    len = ($urandom_range(15) == 0) ? $urandom_range(70, 60)
                                                    : $urandom_range(8, 1);
                else
                    len = $urandom_range(3, 1);
                repeat (len) run = {run, pick_pattern_byte()};
                if (!pat_open)
                    cur_pattern.delete();
                foreach (run[i])
                    cur_pattern = {cur_pattern, run[i]};
                pat_open = (choice >= 22);
                send_run(run, 1'b1, !pat_open);
            end
            else
            begin
                if (choice < 36)
                begin
                    // noise: any byte value
                    repeat ($urandom_range(12, 1)) run = {run, 8'($urandom_range(255))};
                end
                else if ($urandom_range(79) == 0)
                begin
                    // text around the store depth
                    repeat ($urandom_range(262, 250)) run = {run, pick_letter()};
                end
                else
                begin
                    run = text_like(cur_pattern);
                end
                send_run(run, 1'b0, 1'b1);
                if ($urandom_range(39) == 0)
                    wait_for_verdicts();
            end
        end
        wait_for_verdicts();
    endtask

    // Stimulus
    initial
    begin
        in_valid       = 1'b0;
        in_data        = '0;
        rst_n          = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        beats_sent     = 0;
        pat_open       = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty pattern after reset matches nothing
        send_str("a", 1'b0, 1'b1);
        // question mark and star
        send_str("a?*", 1'b1, 1'b1);
        send_str("abzz", 1'b0, 1'b1);
        // lone star against a zero byte
        send_str("*", 1'b1, 1'b1);
        send_beat(8'h00, 1'b0, 1'b1);
        // trailing stars are skipped
        send_str("b**", 1'b1, 1'b1);
        send_str("b", 1'b0, 1'b1);
        // text against an open pattern, then extend that pattern
        send_beat(8'hFF, 1'b1, 1'b0);
        send_beat(8'hFF, 1'b0, 1'b1);
        send_str("?", 1'b1, 1'b1);
        send_beat(8'hFF, 1'b0, 1'b0);
        send_beat(8'h00, 1'b0, 1'b1);
        // single wildcard refuses a longer text
        send_str("?", 1'b1, 1'b1);
        send_str("ab", 1'b0, 1'b1);
        // star that has to backtrack
        send_str("*ab", 1'b1, 1'b1);
        send_str("aab", 1'b0, 1'b1);
        wait_for_verdicts();
        cur_pattern = '{SYM_ANY_RUN, 8'h61, 8'h62};

        run_phase(28, 74, 340);
        run_phase(74, 28, 655);
        run_phase(0, 0, 975);

        repeat (200) @(posedge clk);
        if (board.mismatches == 0 && board.pending_verdicts.size() == 0)
        begin
            $display("[wildcard_glob_matcher_unit] OK");
        end
        else
        begin
            $display("[wildcard_glob_matcher_unit] ERROR");
        end
        $finish;
    end
endmodule
